// ----- hw/rtl/binary_image_pixel_replicator_assert.svh -----
// Assertion macros for the binary image pixel replicator.
// Included by the RTL modules that carry checks; no other dependencies.
`ifndef BINARY_IMAGE_PIXEL_REPLICATOR_ASSERT_SVH
`define BINARY_IMAGE_PIXEL_REPLICATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BIPR_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BIPR_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bipr_pkg.sv -----
// Shared constants and types for the binary image pixel replicator.
// No dependencies; used by every RTL module of the block.
package bipr_pkg;

    localparam int WORD_BITS       = 32;
    localparam int MAX_LINE_PIXELS = 1024;
    // Line store address; counters one bit wider to hold the depth itself
    localparam int STORE_AW        = $clog2(MAX_LINE_PIXELS);
    localparam int LINE_CW         = STORE_AW + 1;
    // Replication factor and per-word pixel count, 1..32
    localparam int FACT_W          = 6;
    localparam int WIDTH_W         = 11;
    localparam int CFG_AW          = 1;
    localparam int CFG_DW          = 11;

    localparam logic [FACT_W-1:0]  SCALE_RESET = FACT_W'(2);
    localparam logic [LINE_CW-1:0] WIDTH_RESET = LINE_CW'(MAX_LINE_PIXELS);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_AW-1:0] {
        REG_SCALE = 1'b0,
        REG_WIDTH = 1'b1
    } cfg_reg_t;

    // One classified input beat
    typedef struct packed {
        logic                 replay;
        logic [WORD_BITS-1:0] pixels;
        logic [FACT_W-1:0]    npix;
        logic                 last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ----- hw/rtl/bipr_front.sv -----
// Front end: accepts input beats, tracks the source pixel position in the line
// and classifies each beat into a command. Depends on bipr_pkg.
module bipr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            line_clear,
    input  logic [bipr_pkg::LINE_CW-1:0]    line_width,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bipr_pkg::WORD_BITS-1:0]  s_tdata,   // pixel_word
    input  logic                            s_tuser,   // mode
    input  bipr_pkg::fifo_stat_t            stat,
    output logic                            push,
    output bipr_pkg::cmd_t                  cmd
);

    logic [bipr_pkg::LINE_CW-1:0] pos_reg;
    logic [bipr_pkg::LINE_CW-1:0] pos_next;
    logic [bipr_pkg::LINE_CW-1:0] pos_eff;
    logic [bipr_pkg::LINE_CW-1:0] remaining;
    logic                         last;

    // Count the valid pixels of this word and spot the line end
    assign pos_eff   = (pos_reg >= line_width) ? '0 : pos_reg;
    assign remaining = line_width - pos_eff;
    assign last      = (remaining <= bipr_pkg::LINE_CW'(bipr_pkg::WORD_BITS));

    assign s_tready = !stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        cmd.replay = s_tuser;
        cmd.pixels = s_tdata;
        cmd.last   = last;
        cmd.npix   = last ? remaining[bipr_pkg::FACT_W-1:0]
                          : bipr_pkg::FACT_W'(bipr_pkg::WORD_BITS);
    end

    // Advance the position on each pixel beat, wrap at line end
    always_comb
    begin
        pos_next = pos_reg;
        if (push && !s_tuser)
        begin
            pos_next = last ? '0 : pos_eff + bipr_pkg::LINE_CW'(bipr_pkg::WORD_BITS);
        end
        if (line_clear)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ----- hw/rtl/bipr_cmd_fifo.sv -----
// Short command queue between the front end and the expansion sequencer.
// Depends on bipr_pkg.
module bipr_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bipr_pkg::cmd_t       cmd_in,
    input  logic                 pop,
    output bipr_pkg::cmd_t       cmd_out,
    output bipr_pkg::fifo_stat_t stat
);

    bipr_pkg::cmd_t                 slot_reg [bipr_pkg::FIFO_DEPTH];
    logic [bipr_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [bipr_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [bipr_pkg::FIFO_AW:0]     count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign stat.full  = (count_reg == (bipr_pkg::FIFO_AW + 1)'(bipr_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign cmd_out    = slot_reg[rd_ptr_reg];

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bipr_pkg::FIFO_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bipr_pkg::FIFO_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (bipr_pkg::FIFO_AW + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (bipr_pkg::FIFO_AW + 1)'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/bipr_back.sv -----
// Back end: expands one source pixel per cycle, unless the output stalls, into
// packed output words, keeps the expanded line in a store and replays it.
// Depends on bipr_pkg and the assertion header.
`include "binary_image_pixel_replicator_assert.svh"

module bipr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            line_clear,
    input  logic [bipr_pkg::FACT_W-1:0]     scale,
    input  bipr_pkg::fifo_stat_t            stat,
    input  bipr_pkg::cmd_t                  cmd,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bipr_pkg::WORD_BITS-1:0]  m_tdata,   // out_word
    output logic                            m_tlast    // line_end
);

    localparam int WB = bipr_pkg::WORD_BITS;
    localparam int FW = bipr_pkg::FACT_W;
    localparam int CW = bipr_pkg::LINE_CW;
    localparam int AW = bipr_pkg::STORE_AW;
    localparam logic [FW-1:0] BL_FULL = FW'(WB);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PIX    = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_REPLAY = 4'b1000
    } state_t;

    // Ones in the low m bits, m from 0 to the word width
    function automatic logic [WB-1:0] ones_low(input logic [FW-1:0] m);
        logic [WB:0] t;
        t = ((WB + 1)'(1) << m) - (WB + 1)'(1);
        return t[WB-1:0];
    endfunction

    state_t          state_reg, state_next;
    logic [WB-1:0]   pix_reg, pix_next;
    logic [FW-1:0]   cnt_reg, cnt_next;
    logic            last_reg, last_next;
    logic [WB-1:0]   acc_reg, acc_next;
    logic [FW-1:0]   bits_left_reg, bl_next;
    logic [CW-1:0]   swi_reg, swi_next;
    logic [CW-1:0]   stored_reg, stored_next;
    logic [AW-1:0]   rpl_idx_reg, rpl_next;
    logic            rpl_end_reg, rpl_end_next;
    logic [WB-1:0]   rd_data_reg;
    logic            out_valid_reg;
    logic [WB-1:0]   out_word_reg;
    logic            out_last_reg;
    logic [WB-1:0]   line_store [bipr_pkg::MAX_LINE_PIXELS];

    logic            out_free;
    logic            emit;
    logic [WB-1:0]   emit_word;
    logic            emit_last;
    logic            store_we;
    logic            mem_re;

    logic            px_bit;
    logic            fits;
    logic            final_px;
    logic [FW-1:0]   rem;
    logic [WB-1:0]   full_word;
    logic [WB-1:0]   part_acc;
    logic [WB-1:0]   carry_acc;

    assign out_free = !out_valid_reg || m_tready;

    // One pixel step: fill f copies of the leading pixel into the accumulator
    assign px_bit    = pix_reg[WB-1];
    assign fits      = (scale < bits_left_reg);
    assign final_px  = (cnt_reg == FW'(1));
    assign rem       = scale - bits_left_reg;
    assign full_word = acc_reg | (px_bit ? ones_low(bits_left_reg) : '0);
    assign part_acc  = acc_reg | (px_bit ? (ones_low(scale) << (bits_left_reg - scale)) : '0);
    assign carry_acc = px_bit ? ~ones_low(BL_FULL - rem) : '0;

    always_comb
    begin
        state_next   = state_reg;
        pix_next     = pix_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        bl_next      = bits_left_reg;
        swi_next     = swi_reg;
        stored_next  = stored_reg;
        rpl_next     = rpl_idx_reg;
        rpl_end_next = rpl_end_reg;
        pop          = 1'b0;
        mem_re       = 1'b0;
        emit         = 1'b0;
        emit_word    = '0;
        emit_last    = 1'b0;
        store_we     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop = 1'b1;
                    if (cmd.replay)
                    begin
                        // Drop a replay when no line is stored
                        if (stored_reg != '0)
                        begin
                            mem_re       = 1'b1;
                            rpl_end_next = ({1'b0, rpl_idx_reg} + CW'(1) == stored_reg);
                            rpl_next     = rpl_end_next ? '0 : rpl_idx_reg + AW'(1);
                            state_next   = ST_REPLAY;
                        end
                    end
                    else
                    begin
                        pix_next   = cmd.pixels;
                        cnt_next   = cmd.npix;
                        last_next  = cmd.last;
                        state_next = ST_PIX;
                    end
                end
            end
            ST_PIX:
            begin
                if (out_free)
                begin
                    pix_next = pix_reg << 1;
                    cnt_next = cnt_reg - FW'(1);
                    if (fits)
                    begin
                        acc_next = part_acc;
                        bl_next  = bits_left_reg - scale;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_word = full_word;
                        emit_last = last_reg && final_px && (rem == '0);
                        store_we  = 1'b1;
                        swi_next  = swi_reg + CW'(1);
                        acc_next  = carry_acc;
                        bl_next   = BL_FULL - rem;
                    end
                    if (final_px)
                    begin
                        if (!last_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (bl_next != BL_FULL)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            stored_next = swi_next;
                            swi_next    = '0;
                            rpl_next    = '0;
                            state_next  = ST_IDLE;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                // Emit the partial word, zero padded, and close the line
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_word   = acc_reg;
                    emit_last   = 1'b1;
                    store_we    = 1'b1;
                    stored_next = swi_reg + CW'(1);
                    swi_next    = '0;
                    rpl_next    = '0;
                    acc_next    = '0;
                    bl_next     = BL_FULL;
                    state_next  = ST_IDLE;
                end
            end
            ST_REPLAY:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_word  = rd_data_reg;
                    emit_last  = rpl_end_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop the line in progress and the stored line
        if (line_clear)
        begin
            acc_next    = '0;
            bl_next     = BL_FULL;
            swi_next    = '0;
            stored_next = '0;
            rpl_next    = '0;
            state_next  = ST_IDLE;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            bits_left_reg <= BL_FULL;
            swi_reg       <= '0;
            stored_reg    <= '0;
            rpl_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            bits_left_reg <= bl_next;
            swi_reg       <= swi_next;
            stored_reg    <= stored_next;
            rpl_idx_reg   <= rpl_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pix_reg     <= pix_next;
        cnt_reg     <= cnt_next;
        last_reg    <= last_next;
        rpl_end_reg <= rpl_end_next;
        if (emit)
        begin
            out_word_reg <= emit_word;
            out_last_reg <= emit_last;
        end
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we && !swi_reg[CW-1])
        begin
            line_store[swi_reg[AW-1:0]] <= emit_word;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_store[rpl_idx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;

    `BIPR_IMPLY(a_flush_partial, clk, rst_n, state_reg == ST_FLUSH, bits_left_reg != BL_FULL, "flush with an empty accumulator")
    `BIPR_IMPLY(a_replay_has_line, clk, rst_n, state_reg == ST_REPLAY, stored_reg != '0, "replay without a stored line")
    `BIPR_IMPLY(a_store_in_range, clk, rst_n, store_we, !swi_reg[CW-1], "line store write past its depth")
    `BIPR_IMPLY(a_replay_idx_range, clk, rst_n, stored_reg != '0, {1'b0, rpl_idx_reg} < stored_reg, "replay index beyond stored line")
    `BIPR_NEXT(a_flush_closes_line, clk, rst_n, state_reg == ST_FLUSH && out_free && !line_clear, stored_reg != '0 && swi_reg == '0 && state_reg == ST_IDLE, "flush did not close the line")

endmodule

// ----- hw/rtl/binary_image_pixel_replicator.sv -----
// Top level of the binary image pixel replicator: configuration registers,
// front end, command queue and expansion back end. Depends on bipr_pkg.
//
// Upscales a one-bit-per-pixel image by an integer factor (1..32). A pixel
// beat (tuser 0) carries 32 pixels MSB first; only those up to the configured
// line width count. Each pixel is repeated scale_factor times into packed
// 32-bit output words; a partial word at line end is zero padded and marked
// with tlast. A replay beat (tuser 1) returns the next stored word of the last
// completed line, wrapping after its last word, so factor-1 replay passes give
// vertical replication; a replay with no completed line gives no output.
// A pixel beat is dispatched from the queue, then its valid pixels are
// expanded one at a time, with a flush step for a partial word at line end;
// a replay beat is dispatched with the line store read, then emitted. The rate
// is set by the expansion step, which consumes one source pixel per cycle and
// produces at most one output word per cycle. A four-entry queue decouples
// input from expansion, and output back-pressure stalls expansion.
// Writing either configuration register abandons the current and stored line.
module binary_image_pixel_replicator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bipr_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [bipr_pkg::CFG_DW-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bipr_pkg::WORD_BITS-1:0]  s_tdata,   // [31:0] pixel_word
    input  logic                            s_tuser,   // [0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bipr_pkg::WORD_BITS-1:0]  m_tdata,   // [31:0] out_word
    output logic                            m_tlast    // line_end
);

    logic [bipr_pkg::FACT_W-1:0]  scale_reg;
    logic [bipr_pkg::LINE_CW-1:0] width_reg;
    logic [bipr_pkg::FACT_W-1:0]  scale_in;
    logic [bipr_pkg::WIDTH_W-1:0] width_in;
    logic [bipr_pkg::FACT_W-1:0]  scale_clamped;
    logic [bipr_pkg::LINE_CW-1:0] width_clamped;

    bipr_pkg::cmd_t       cmd_push;
    bipr_pkg::cmd_t       cmd_head;
    bipr_pkg::fifo_stat_t stat;
    logic                 push;
    logic                 pop;

    // Clamp written values into their usable ranges
    assign scale_in = cfg_wdata[bipr_pkg::FACT_W-1:0];
    assign width_in = cfg_wdata[bipr_pkg::WIDTH_W-1:0];

    always_comb
    begin
        if (scale_in == '0)
        begin
            scale_clamped = bipr_pkg::FACT_W'(1);
        end
        else if (scale_in > bipr_pkg::FACT_W'(bipr_pkg::WORD_BITS))
        begin
            scale_clamped = bipr_pkg::FACT_W'(bipr_pkg::WORD_BITS);
        end
        else
        begin
            scale_clamped = scale_in;
        end

        if (width_in == '0)
        begin
            width_clamped = bipr_pkg::LINE_CW'(1);
        end
        else if (width_in > bipr_pkg::WIDTH_W'(bipr_pkg::MAX_LINE_PIXELS))
        begin
            width_clamped = bipr_pkg::LINE_CW'(bipr_pkg::MAX_LINE_PIXELS);
        end
        else
        begin
            width_clamped = bipr_pkg::LINE_CW'(width_in);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= bipr_pkg::SCALE_RESET;
            width_reg <= bipr_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bipr_pkg::cfg_reg_t'(cfg_addr))
                bipr_pkg::REG_SCALE: scale_reg <= scale_clamped;
                bipr_pkg::REG_WIDTH: width_reg <= width_clamped;
                default: ;
            endcase
        end
    end

    bipr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_clear (cfg_we),
        .line_width (width_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .stat       (stat),
        .push       (push),
        .cmd        (cmd_push)
    );

    bipr_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_push),
        .pop     (pop),
        .cmd_out (cmd_head),
        .stat    (stat)
    );

    bipr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_clear (cfg_we),
        .scale      (scale_reg),
        .stat       (stat),
        .cmd        (cmd_head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- test/binary_image_pixel_replicator_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the one-bit-per-pixel upscaler.
// Needs bipr_pkg and binary_image_pixel_replicator; predicts every output beat.
module binary_image_pixel_replicator_test;

    localparam logic MODE_PIXELS = 1'b0;
    localparam logic MODE_REPLAY = 1'b1;

    localparam int RANDOM_BEATS   = 120;
    localparam int REPLAY_CAP     = 24;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    localparam int WB    = bipr_pkg::WORD_BITS;
    localparam int DEPTH = bipr_pkg::MAX_LINE_PIXELS;

    typedef struct {
        logic          mode;
        logic [WB-1:0] pixels;
    } src_beat_t;

    typedef struct {
        logic [WB-1:0] word;
        logic          line_end;
    } out_beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [bipr_pkg::CFG_AW-1:0]   cfg_addr = bipr_pkg::REG_SCALE;
    logic [bipr_pkg::CFG_DW-1:0]   cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [WB-1:0]                 s_tdata = '0;   // [31:0] pixel_word
    logic                          s_tuser = 1'b0; // [0] mode
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [WB-1:0]                 m_tdata;        // [31:0] out_word
    logic                          m_tlast;        // line_end

    // Beats waiting to be driven and output beats still owed by the block
    src_beat_t src_beats[$];
    out_beat_t expected_words[$];

    // Shadow of the configuration and of the expansion state
    logic [bipr_pkg::FACT_W-1:0]  cur_factor = bipr_pkg::SCALE_RESET;
    logic [bipr_pkg::WIDTH_W-1:0] cur_width = bipr_pkg::WIDTH_W'(DEPTH);
    logic [WB-1:0]                word_fill = '0;
    logic [5:0]                   bits_free = 6'd32;
    logic [bipr_pkg::LINE_CW-1:0] src_pos = '0;
    logic [bipr_pkg::LINE_CW-1:0] store_wr = '0;
    logic [bipr_pkg::LINE_CW-1:0] replay_pos = '0;
    logic [bipr_pkg::LINE_CW-1:0] line_words = '0;
    logic [WB-1:0]                line_store [DEPTH];

    int unsigned errors = 0;
    int unsigned beats_queued = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned quiet_cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    binary_image_pixel_replicator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none in calm stretches
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned eff_factor();
        if (cur_factor == 0)
            return 1;
        else if (cur_factor > 32)
            return 32;
        else
            return cur_factor;
    endfunction

    function automatic int unsigned eff_width();
        if (cur_width == 0)
            return 1;
        else if (cur_width > DEPTH)
            return DEPTH;
        else
            return cur_width;
    endfunction

    function automatic void drop_line();
        word_fill  = '0;
        bits_free  = 6'd32;
        src_pos    = '0;
        store_wr   = '0;
        replay_pos = '0;
        line_words = '0;
    endfunction

    // Owe one expanded word and keep it in the line store
    function automatic void emit_word(input logic [WB-1:0] word, input logic line_end);
        out_beat_t beat;
        beat.word     = word;
        beat.line_end = line_end;
        expected_words.push_back(beat);
        if (store_wr < DEPTH)
            line_store[store_wr] = word;
        store_wr++;
    endfunction

    // Work out the output beats that one accepted input beat causes
    function automatic void expand_beat(input logic mode, input logic [WB-1:0] pixels);
        out_beat_t   beat;
        int unsigned f;
        int unsigned w;
        int unsigned n;
        bit          last_beat;
        if (mode == MODE_REPLAY)
        begin
            if (line_words == 0)
                return;
            if (replay_pos >= line_words)
                replay_pos = '0;
            beat.word     = line_store[replay_pos];
            beat.line_end = (replay_pos + 1 == line_words);
            expected_words.push_back(beat);
            replay_pos++;
            if (replay_pos >= line_words)
                replay_pos = '0;
            return;
        end
        f = eff_factor();
        w = eff_width();
        if (src_pos >= w)
            src_pos = '0;
        n = w - src_pos;
        if (n > 32)
            n = 32;
        last_beat = (src_pos + n == w);
        for (int unsigned i = 0; i < n; i++)
        begin
            for (int unsigned c = 0; c < f; c++)
            begin
                bits_free--;
                word_fill[bits_free] = pixels[31 - i];
                if (bits_free == 0)
                begin
                    emit_word(word_fill, last_beat && (i + 1 == n) && (c + 1 == f));
                    word_fill = '0;
                    bits_free = 6'd32;
                end
            end
        end
        src_pos += n;
        if (last_beat)
        begin
            if (bits_free != 6'd32)
                emit_word(word_fill, 1'b1);
            word_fill  = '0;
            bits_free  = 6'd32;
            src_pos    = '0;
            line_words = store_wr;
            store_wr   = '0;
            replay_pos = '0;
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [WB-1:0] want,
                                          input logic [WB-1:0] got);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function automatic void add_beat(input logic mode, input logic [WB-1:0] pixels);
        src_beat_t beat;
        beat.mode   = mode;
        beat.pixels = pixels;
        src_beats.push_back(beat);
        beats_queued++;
    endfunction

    // Write one register while the block is idle and drop the shadow line
    task automatic write_reg(input bipr_pkg::cfg_reg_t idx,
                             input logic [bipr_pkg::CFG_DW-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == bipr_pkg::REG_SCALE)
            cur_factor = value[bipr_pkg::FACT_W-1:0];
        else
            cur_width = value[bipr_pkg::WIDTH_W-1:0];
        drop_line();
    endtask

    // Let every queued beat go in and every owed word come out
    task automatic wait_idle();
        while (src_beats.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Source side: predict on accept, then hold, idle or present the next beat
    always @(posedge clk)
    begin
        src_beat_t beat;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expand_beat(s_tuser, s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (src_beats.size() != 0)
                begin
                    beat = src_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= beat.mode;
                    s_tdata  <= beat.pixels;
                    tx_gap   = pick_gap(tx_calm);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each accepted word against the oldest one owed
    always @(posedge clk)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    note_mismatch("unexpected word", '0, m_tdata);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.word)
                        note_mismatch("out_word", want.word, m_tdata);
                    if (m_tlast !== want.line_end)
                        note_mismatch("line_end", 32'(want.line_end), 32'(m_tlast));
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_stall = pick_gap(rx_calm);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int unsigned f_eff;
        int unsigned w_eff;
        int unsigned nlines;
        int unsigned nbeats;
        int unsigned words;
        int unsigned nreps;
        int unsigned start_count;
        int unsigned r;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Replay with no completed line, then a line left open at reset settings
        add_beat(MODE_REPLAY, 32'hFFFF_FFFF);
        add_beat(MODE_PIXELS, 32'h8000_0001);
        wait_idle();

        // Factor and width of zero act as one
        write_reg(bipr_pkg::REG_SCALE, '0);
        write_reg(bipr_pkg::REG_WIDTH, '0);
        add_beat(MODE_PIXELS, 32'hFFFF_FFFF);
        add_beat(MODE_PIXELS, 32'h7FFF_FFFF);
        add_beat(MODE_REPLAY, 32'h0000_0000);
        add_beat(MODE_REPLAY, 32'h0000_0000);
        wait_idle();

        // Oversized factor clamps to 32; replay wraps past line end
        write_reg(bipr_pkg::REG_SCALE, bipr_pkg::CFG_DW'(63));
        write_reg(bipr_pkg::REG_WIDTH, bipr_pkg::CFG_DW'(3));
        add_beat(MODE_PIXELS, 32'hA000_0000);
        repeat (4) add_beat(MODE_REPLAY, 32'h0000_0000);
        wait_idle();

        // Largest factor, a line just over one source word
        write_reg(bipr_pkg::REG_SCALE, bipr_pkg::CFG_DW'(32));
        write_reg(bipr_pkg::REG_WIDTH, bipr_pkg::CFG_DW'(33));
        add_beat(MODE_PIXELS, 32'hFFFF_FFFF);
        add_beat(MODE_PIXELS, 32'h8000_0000);
        add_beat(MODE_REPLAY, 32'h0000_0000);
        wait_idle();

        // Odd factor with partial flush; replay while the next line overwrites
        write_reg(bipr_pkg::REG_SCALE, bipr_pkg::CFG_DW'(3));
        write_reg(bipr_pkg::REG_WIDTH, bipr_pkg::CFG_DW'(40));
        add_beat(MODE_PIXELS, 32'h1234_5678);
        add_beat(MODE_PIXELS, 32'hF000_0000);
        add_beat(MODE_REPLAY, 32'h0000_0000);
        add_beat(MODE_REPLAY, 32'h0000_0000);
        add_beat(MODE_PIXELS, 32'h5555_AAAA);
        add_beat(MODE_REPLAY, 32'h0000_0000);
        add_beat(MODE_REPLAY, 32'h0000_0000);
        wait_idle();

        // Oversized width clamps; a write drops both lines so replay gives nothing
        write_reg(bipr_pkg::REG_WIDTH, bipr_pkg::CFG_DW'(2047));
        write_reg(bipr_pkg::REG_SCALE, bipr_pkg::CFG_DW'(1));
        add_beat(MODE_PIXELS, 32'hDEAD_BEEF);
        add_beat(MODE_REPLAY, 32'h0000_0000);
        wait_idle();

        // Random phases: whole lines with random pixels followed by replay passes
        start_count = beats_queued;
        while (beats_queued - start_count < RANDOM_BEATS)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 3);
            if (r != 1)
            begin
                case ($urandom_range(0, 9))
                    0:       write_reg(bipr_pkg::REG_SCALE, '0);
                    1:       write_reg(bipr_pkg::REG_SCALE, bipr_pkg::CFG_DW'(32));
                    2:       write_reg(bipr_pkg::REG_SCALE,
                                       bipr_pkg::CFG_DW'($urandom_range(33, 63)));
                    3:       write_reg(bipr_pkg::REG_SCALE, bipr_pkg::CFG_DW'($urandom));
                    default: write_reg(bipr_pkg::REG_SCALE,
                                       bipr_pkg::CFG_DW'($urandom_range(1, 8)));
                endcase
            end
            if (r != 0)
            begin
                case ($urandom_range(0, 19))
                    0:       write_reg(bipr_pkg::REG_WIDTH,
                                       bipr_pkg::CFG_DW'($urandom_range(1025, 2047)));
                    1:       write_reg(bipr_pkg::REG_WIDTH, bipr_pkg::CFG_DW'(DEPTH));
                    2:       write_reg(bipr_pkg::REG_WIDTH, '0);
                    3, 4, 5: write_reg(bipr_pkg::REG_WIDTH,
                                       bipr_pkg::CFG_DW'($urandom_range(97, 400)));
                    default: write_reg(bipr_pkg::REG_WIDTH,
                                       bipr_pkg::CFG_DW'($urandom_range(1, 96)));
                endcase
            end
            f_eff  = eff_factor();
            w_eff  = eff_width();
            words  = (w_eff * f_eff + 31) / 32;
            nlines = (w_eff > 256) ? 1 : $urandom_range(1, 3);
            for (int unsigned line_idx = 0; line_idx < nlines; line_idx++)
            begin
                nbeats = (w_eff + 31) / 32;
                // Sometimes leave the last line open for the next write to drop
                if (line_idx + 1 == nlines && $urandom_range(0, 5) == 0)
                    nbeats = $urandom_range(1, nbeats);
                for (int unsigned b = 0; b < nbeats; b++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        add_beat(MODE_REPLAY, $urandom);
                    add_beat(MODE_PIXELS, $urandom);
                end
                nreps = (f_eff - 1) * words;
                if ($urandom_range(0, 4) == 0)
                    nreps = $urandom_range(0, words + 2);
                if (nreps > REPLAY_CAP)
                    nreps = REPLAY_CAP;
                repeat (nreps) add_beat(MODE_REPLAY, $urandom);
            end
            wait_idle();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bipr_pkg.sv
hw/rtl/bipr_front.sv
hw/rtl/bipr_cmd_fifo.sv
hw/rtl/bipr_back.sv
hw/rtl/binary_image_pixel_replicator.sv
test/binary_image_pixel_replicator_test.sv
